// File: rtl/core/mmsd_pkg.sv
// ----------------------------------------------------------------------------
// mmsd_pkg
// Shared types and constants for the min-makespan subset DP unit.
// ----------------------------------------------------------------------------
package mmsd_pkg;

    localparam int unsigned SPAN_W   = 28;
    localparam int unsigned WCOUNT_W = 4;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    localparam logic [1:0] REG_WORKER_COUNT = 2'd0;

    typedef struct packed {
        logic load;
        logic sum_start;
        logic sum_step;
        logic copy_step;
        logic dp_start;
        logic dp_step;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_done;
        logic copy_done;
        logic dp_done;
        logic round_last;
    } t_dp_status;

endpackage

// File: rtl/core/mmsd_datapath.sv
// ----------------------------------------------------------------------------
// mmsd_datapath
// Job store, subset-sum and best-load memories, mask/submask walkers.
// ----------------------------------------------------------------------------
module mmsd_datapath import mmsd_pkg::*; #(
    parameter int unsigned MAX_JOBS    = 12,
    parameter int unsigned MAX_WORKERS = 12,
    parameter int unsigned JOB_WIDTH   = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [JOB_WIDTH-1:0]  i_job_time,
    input  logic [WCOUNT_W-1:0]   i_workers,
    output t_dp_status            o_status,
    output logic [SPAN_W-1:0]     o_makespan,
    output logic                  o_overflow
);
    localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
    localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int unsigned DEPTH = 1 << MAX_JOBS;
    localparam int unsigned WRK_W = $clog2(MAX_WORKERS + 1);
    // internal sums stay exact: up to MAX_JOBS jobs of JOB_WIDTH bits
    localparam int unsigned SUM_W = JOB_WIDTH + MAX_JOBS;

    logic [JOB_WIDTH-1:0] r_jobs [MAX_JOBS];
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [SUM_W-1:0]     r_sum [DEPTH];
    logic [SUM_W-1:0]     r_best [DEPTH];
    logic [SUM_W-1:0]     r_sum_q;
    logic [SUM_W-1:0]     r_best_q;
    logic [SUM_W-1:0]     r_res;
    logic                 r_ph;

    // walker state
    logic [MAX_JOBS:0]    r_m;      // current mask (extra bit holds "full")
    logic [MAX_JOBS-1:0]  r_sub;
    logic [SUM_W-1:0]     r_acc;
    logic [WRK_W-1:0]     r_round;
    logic [WRK_W-1:0]     r_wlim;

    logic [MAX_JOBS:0]    w_full;
    logic [MAX_JOBS-1:0]  w_m;
    logic [MAX_JOBS-1:0]  w_last_m;
    logic [IDX_W-1:0]     w_low;
    logic [SUM_W-1:0]     w_c, w_min;
    logic [MAX_JOBS-1:0]  w_sub_n;
    logic [MAX_JOBS-1:0]  w_sum_addr;
    logic [MAX_JOBS-1:0]  w_best_addr;
    logic                 w_step;
    logic                 w_rd;
    logic                 w_sum_we;
    logic                 w_best_we;
    logic [SUM_W-1:0]     w_sum_wd;
    logic [SUM_W-1:0]     w_best_wd;

    assign w_full   = (MAX_JOBS+1)'(1) << r_count;
    assign w_m      = r_m[MAX_JOBS-1:0];
    assign w_last_m = w_full[MAX_JOBS-1:0] - 1'b1;

    always_comb begin
        w_low = '0;
        for (int k = MAX_JOBS - 1; k >= 0; k--) begin
            if (w_m[k]) w_low = IDX_W'(k);
        end
    end

    // each step: read phase, then update phase on the registered read data
    assign w_step  = i_cmd.sum_step || i_cmd.copy_step || i_cmd.dp_step;
    assign w_rd    = w_step && !r_ph;

    always_comb begin
        if (i_cmd.sum_step)
            w_sum_addr = w_m & (w_m - 1'b1);
        else if (i_cmd.copy_step)
            w_sum_addr = w_m;
        else
            w_sum_addr = r_sub;
    end
    assign w_best_addr = w_m ^ r_sub;

    assign w_c     = (r_sum_q > r_best_q) ? r_sum_q : r_best_q;
    assign w_min   = (w_c < r_acc) ? w_c : r_acc;
    assign w_sub_n = (r_sub - 1'b1) & w_m;

    assign w_sum_we  = i_cmd.sum_step && r_ph;
    assign w_sum_wd  = (w_m == '0) ? '0 : r_sum_q + SUM_W'(r_jobs[w_low]);
    assign w_best_we = (i_cmd.copy_step && r_ph) || (i_cmd.dp_step && r_ph && r_sub == '0);
    assign w_best_wd = i_cmd.copy_step ? r_sum_q : w_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (r_count < CNT_W'(MAX_JOBS)) begin
                r_jobs[r_count[IDX_W-1:0]] <= i_job_time;
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) r_sum[w_m] <= w_sum_wd;
        if (w_rd) r_sum_q <= r_sum[w_sum_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_best_we) r_best[w_m] <= w_best_wd;
        if (w_rd) r_best_q <= r_best[w_best_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_best_we && w_m == w_last_m) r_res <= w_best_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 1'b0;
        end else if (i_cmd.sum_start) begin
            r_ph <= 1'b0;
        end else if (w_step) begin
            r_ph <= !r_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_start) begin
            r_m     <= '0;
            r_round <= WRK_W'(1);
            if (i_workers == '0)
                r_wlim <= WRK_W'(1);
            else if (32'(i_workers) > MAX_WORKERS)
                r_wlim <= WRK_W'(MAX_WORKERS);
            else
                r_wlim <= WRK_W'(i_workers);
        end else if (i_cmd.sum_step && r_ph) begin
            r_m <= (r_m + 1'b1 == w_full) ? '0 : r_m + 1'b1;
        end else if (i_cmd.copy_step && r_ph) begin
            r_m <= r_m + 1'b1;
        end else if (i_cmd.dp_start) begin
            r_m     <= w_full - 1'b1;
            r_sub   <= w_last_m;
            r_acc   <= '1;
            r_round <= r_round + 1'b1;
        end else if (i_cmd.dp_step && r_ph) begin
            if (r_sub == '0) begin
                if (w_m != '0) begin
                    r_m   <= r_m - 1'b1;
                    r_sub <= w_m - 1'b1;
                    r_acc <= '1;
                end
            end else begin
                r_acc <= w_min;
                r_sub <= w_sub_n;
            end
        end
    end

    assign o_status.sum_done   = i_cmd.sum_step && r_ph && (r_m + 1'b1 == w_full);
    assign o_status.copy_done  = i_cmd.copy_step && r_ph && (r_m + 1'b1 == w_full);
    assign o_status.dp_done    = i_cmd.dp_step && r_ph && (r_sub == '0) && (w_m == '0);
    assign o_status.round_last = (r_round >= r_wlim);

    assign o_makespan = (r_res > SUM_W'(SPAN_MAX)) ? SPAN_MAX : r_res[SPAN_W-1:0];
    assign o_overflow = r_ovf;
endmodule

// File: rtl/core/mmsd_ctrl.sv
// ----------------------------------------------------------------------------
// mmsd_ctrl
// Sequencer: load, subset sums, copy, DP rounds, result hold.
// ----------------------------------------------------------------------------
module mmsd_ctrl import mmsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_last,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_ready,
    output logic       o_out_valid,
    output logic       o_capture,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_SUM  = 6'b000010,
        S_COPY = 6'b000100,
        S_NEXT = 6'b001000,
        S_DP   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_oval;
    logic   w_acc;

    assign o_ready = (r_state == S_LOAD);
    assign w_acc   = i_valid && o_ready;
    assign o_out_valid = r_oval;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        o_capture = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = w_acc;
                if (w_acc && i_last) begin
                    o_cmd.sum_start = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_done) n_state = S_COPY;
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.copy_done) n_state = S_NEXT;
            end
            S_NEXT: begin
                if (i_status.round_last) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.dp_start = 1'b1;
                    n_state = S_DP;
                end
            end
            S_DP: begin
                o_cmd.dp_step = 1'b1;
                if (i_status.dp_done) n_state = S_NEXT;
            end
            S_OUT: begin
                if (!r_oval || i_out_ready) begin
                    o_capture = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_capture) r_oval <= 1'b1;
            else if (i_out_ready) r_oval <= 1'b0;
        end
    end
endmodule

// File: rtl/core/min_makespan_subset_dp_unit.sv
// ----------------------------------------------------------------------------
// min_makespan_subset_dp_unit
// Minimum makespan of a job set over N workers by subset-mask DP.
//
//  channel  | signals                               | dir
//  input    | i_valid/o_ready, i_job_time, i_last_job | in
//  output   | o_valid/i_ready, o_makespan, o_overflow | out
//  config   | psel/penable/pwrite/paddr/pwdata/prdata | APB
//
// Jobs load at one per cycle while the unit is in its load state. After the
// last job: subset sums, then the copy, then per extra worker the submask
// walk (read phase plus update phase per step), then the hand-off.
// Sync active-low reset; the result sits in an output register until
// taken while the next set loads; input stalls from the last job to hand-off.
// ----------------------------------------------------------------------------
module min_makespan_subset_dp_unit import mmsd_pkg::*; #(
    parameter int unsigned MAX_JOBS    = 12,
    parameter int unsigned MAX_WORKERS = 12,
    parameter int unsigned JOB_WIDTH   = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [JOB_WIDTH-1:0] i_job_time,
    input  logic                 i_last_job,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SPAN_W-1:0]    o_makespan,
    output logic                 o_overflow,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [WCOUNT_W-1:0] r_workers;
    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic                w_capture;
    logic [SPAN_W-1:0]   w_span;
    logic                w_ovf;
    logic [SPAN_W-1:0]   r_span;
    logic                r_ovf;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_WORKER_COUNT) ? {28'd0, r_workers} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_workers <= WCOUNT_W'(1);
        end else if (psel && penable && pwrite && paddr == REG_WORKER_COUNT) begin
            r_workers <= pwdata[WCOUNT_W-1:0];
        end
    end

    mmsd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_last(i_last_job),
        .i_out_ready(i_ready), .i_status(w_status), .o_ready(o_ready),
        .o_out_valid(o_valid), .o_capture(w_capture), .o_cmd(w_cmd)
    );

    mmsd_datapath #(
        .MAX_JOBS(MAX_JOBS), .MAX_WORKERS(MAX_WORKERS), .JOB_WIDTH(JOB_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_job_time(i_job_time),
        .i_workers(r_workers), .o_status(w_status), .o_makespan(w_span),
        .o_overflow(w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_span <= w_span;
            r_ovf  <= w_ovf;
        end
    end

    assign o_makespan = r_span;
    assign o_overflow = r_ovf;
endmodule

// File: rtl/core/mmsd_checker.sv
// ----------------------------------------------------------------------------
// mmsd_checker
// Port-level checks for the min-makespan unit.
// ----------------------------------------------------------------------------
module mmsd_checker import mmsd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [SPAN_W-1:0] o_makespan,
    input logic              o_overflow,
    input logic              pready
);
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_makespan) && $stable(o_overflow))
        else $error("result changed while waiting");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");
endmodule

bind min_makespan_subset_dp_unit mmsd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_makespan(o_makespan), .o_overflow(o_overflow), .pready(pready)
);
